// ----- src/planar_pose_integrator_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the planar pose integrator
// Both macros sample on clock and are switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef PLANAR_POSE_INTEGRATOR_ASSERT_SVH
`define PLANAR_POSE_INTEGRATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define PPI_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PPI_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/ppi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppi_pkg: shared types and constants of the planar pose integrator
// Field types, the register index codes, the multiplier operand word and
// the quarter-wave sine entry used to build the lookup ROM.
// ----------------------------------------------------------------------------
package ppi_pkg;

   // Default sine table size, in address bits over one full turn
   localparam int TABLE_BITS_DEF = 10;

   // Register reset values (Q0.16)
   localparam logic [15:0] SMOOTHING_GAIN_RESET = 16'd6554;
   localparam logic [15:0] STEP_TIME_RESET      = 16'd655;

   // Field types
   typedef logic signed [23:0] vel_type;    // Q8.16
   typedef logic signed [31:0] pos_type;    // Q16.16
   typedef logic signed [15:0] angle_type;  // binary angle
   typedef logic signed [15:0] trig_type;   // Q1.15
   typedef logic        [15:0] csr_data_type;

   // Register index codes
   typedef logic [0:0] csr_index_type;
   localparam csr_index_type CSR_SMOOTHING_GAIN = 1'b0;
   localparam csr_index_type CSR_STEP_TIME      = 1'b1;

   // Shared multiplier widths
   localparam int MUL_A_W = 41;
   localparam int MUL_B_W = 17;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   typedef logic signed [MUL_P_W-1:0] mul_prod_type;

   typedef struct packed {
      logic signed [MUL_A_W-1:0] a;
      logic signed [MUL_B_W-1:0] b;
   } mul_op_type;

   localparam real HALF_PI = 1.5707963267948966;

   // round(32767 * sin(pi/2 * k / 2^qbits)), evaluated at elaboration
   function automatic logic [14:0] quarter_sine(input int k, input int qbits);
      real ang;
      ang = HALF_PI * real'(k) * (2.0 ** (-real'(qbits)));
      return 15'($rtoi(32767.0 * $sin(ang) + 0.5));
   endfunction

endpackage

// ----- src/ppi_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppi_mul: shared signed multiplier
// One signed 41 x 17 bit product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module ppi_mul (
   input  logic                  clock,
   input  ppi_pkg::mul_op_type   op,
   output ppi_pkg::mul_prod_type prod
);
   import ppi_pkg::*;

   mul_prod_type prod_ff;
   mul_prod_type prod_in;

   // Form the full-width product
   always_comb begin
      prod_in = op.a * op.b;
   end

   // Register the product
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ----- src/ppi_sine_rom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppi_sine_rom: full-turn sine lookup
// A quarter-wave ROM with registered read; the quadrant folds the address
// and sets the sign. Read data appears in the cycle after the index.
// ----------------------------------------------------------------------------
module ppi_sine_rom #(
   parameter int TABLE_BITS = ppi_pkg::TABLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic [TABLE_BITS-1:0] angle_idx,
   output ppi_pkg::trig_type     sine
);
   import ppi_pkg::*;

   localparam int QUAR_BITS = TABLE_BITS - 2;
   localparam int QUAR_LEN  = 1 << QUAR_BITS;

   logic [14:0]          quarter_rom [QUAR_LEN + 1];
   logic [1:0]           quad;
   logic [QUAR_BITS-1:0] offset;
   logic [QUAR_BITS:0]   rom_addr;
   logic [14:0]          rom_q_ff;
   logic                 neg_ff;

   // Build the quarter-wave table at elaboration
   for (genvar g = 0; g <= QUAR_LEN; g++) begin : g_entry
      localparam logic [14:0] ENTRY = quarter_sine(g, QUAR_BITS);
      assign quarter_rom[g] = ENTRY;
   end

   // Fold the index into the first quadrant
   always_comb begin
      quad   = angle_idx[TABLE_BITS-1 -: 2];
      offset = angle_idx[QUAR_BITS-1:0];
      if (quad[0]) begin
         rom_addr = (QUAR_BITS + 1)'(QUAR_LEN) - {1'b0, offset};
      end else begin
         rom_addr = {1'b0, offset};
      end
   end

   // Read the ROM and hold the sign alongside
   always_ff @(posedge clock) begin
      rom_q_ff <= quarter_rom[rom_addr];
      neg_ff   <= quad[1];
   end

   // Apply the sign for the lower half turn
   assign sine = neg_ff ? -trig_type'({1'b0, rom_q_ff}) : trig_type'({1'b0, rom_q_ff});

endmodule

// ----- src/planar_pose_integrator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_pose_integrator: planar dead reckoning with velocity smoothing
// Smooths the commanded body velocities, rotates them by the heading and
// integrates the pose once per tick word.
// ----------------------------------------------------------------------------
// Usage
//   req_*  : one tick word per handshake (commanded vx, vy, yaw rate, Q8.16).
//   rsp_*  : one result word per tick (pose, heading, smoothed velocities).
//   csr_*  : register write port; index 0 smoothing gain, index 1 tick period.
//            Write only while no tick is in flight.
// Sequence
//   A tick runs through the sequencer steps on the shared 41 x 17 multiplier
//   (ten products, one per cycle) and then loads the result register;
//   rsp_valid rises together with req_ready, so no new tick is taken
//   before the last one has loaded its result.
//   req_ready is high only while the sequencer is idle.
// Stall
//   The result register holds its word while rsp_ready is low; a further
//   tick is accepted and computed meanwhile and waits before loading.
// Reset
//   Synchronous reset clears the pose, heading and velocities to zero and
//   returns the registers to gain 0.1 and tick period 0.01 s.
// ----------------------------------------------------------------------------
module planar_pose_integrator #(
   parameter int TABLE_BITS = ppi_pkg::TABLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ppi_pkg::vel_type       req_cmd_vel_x,
   input  ppi_pkg::vel_type       req_cmd_vel_y,
   input  ppi_pkg::vel_type       req_cmd_turn_rate,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ppi_pkg::pos_type       rsp_pose_x,
   output ppi_pkg::pos_type       rsp_pose_y,
   output ppi_pkg::angle_type     rsp_heading,
   output ppi_pkg::vel_type       rsp_body_vel_x,
   output ppi_pkg::vel_type       rsp_body_vel_y,
   output ppi_pkg::vel_type       rsp_body_turn_rate,
   input  logic                   csr_wr_en,
   input  ppi_pkg::csr_index_type csr_index,
   input  ppi_pkg::csr_data_type  csr_wdata
);
   import ppi_pkg::*;

   `include "planar_pose_integrator_assert.svh"

   localparam int QUAR_LEN = 1 << (TABLE_BITS - 2);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   // Sequencer steps; each but the last issues one product, each but the first consumes the previous one
   typedef logic [3:0] step_type;
   localparam step_type STEP_SMOOTH_X = 4'd0;
   localparam step_type STEP_SMOOTH_Y = 4'd1;
   localparam step_type STEP_SMOOTH_R = 4'd2;
   localparam step_type STEP_VX_COS   = 4'd3;
   localparam step_type STEP_VY_SIN   = 4'd4;
   localparam step_type STEP_VX_SIN   = 4'd5;
   localparam step_type STEP_VY_COS   = 4'd6;
   localparam step_type STEP_WX_DT    = 4'd7;
   localparam step_type STEP_WY_DT    = 4'd8;
   localparam step_type STEP_RATE_DT  = 4'd9;
   localparam step_type STEP_HEADING  = 4'd10;

   // Control and state
   state_type    state_ff, state_in;
   step_type     step_ff, step_in;
   csr_data_type gain_ff, gain_in;
   csr_data_type dt_ff, dt_in;
   pos_type      pos_x_ff, pos_x_in;
   pos_type      pos_y_ff, pos_y_in;
   angle_type    head_ff, head_in;
   vel_type      vel_x_ff, vel_x_in;
   vel_type      vel_y_ff, vel_y_in;
   vel_type      rate_ff, rate_in;
   logic         rsp_valid_ff, rsp_valid_in;

   // Payload
   vel_type      cmd_x_ff, cmd_x_in;
   vel_type      cmd_y_ff, cmd_y_in;
   vel_type      cmd_r_ff, cmd_r_in;
   trig_type     sin_ff, sin_in;
   trig_type     cos_ff, cos_in;
   logic signed [MUL_A_W-1:0] acc_ff, acc_in;
   logic signed [MUL_A_W-1:0] wx_ff, wx_in;
   pos_type      out_x_ff, out_x_in;
   pos_type      out_y_ff, out_y_in;
   angle_type    out_head_ff, out_head_in;
   vel_type      out_vx_ff, out_vx_in;
   vel_type      out_vy_ff, out_vy_in;
   vel_type      out_rate_ff, out_rate_in;

   // Datapath
   logic                  accept;
   logic                  out_load;
   logic signed [24:0]    diff_x, diff_y, diff_r;
   logic [TABLE_BITS-1:0] head_idx, rom_idx;
   trig_type              rom_val;
   mul_op_type            mul_op;
   mul_prod_type          prod;
   logic signed [MUL_A_W-1:0] prod_low;
   vel_type               smooth_step;

   // Add a displacement and clamp to the Q16.16 range
   function automatic pos_type sat_add(input pos_type p, input logic signed [26:0] d);
      logic signed [32:0] s;
      s = 33'(p) + 33'(d);
      if (s[32] != s[31]) begin
         return s[32] ? pos_type'({1'b1, 31'd0}) : pos_type'({1'b0, {31{1'b1}}});
      end
      return s[31:0];
   endfunction

   ppi_mul u_mul (
      .clock (clock),
      .op    (mul_op),
      .prod  (prod)
   );

   ppi_sine_rom #(
      .TABLE_BITS (TABLE_BITS)
   ) u_sine_rom (
      .clock     (clock),
      .angle_idx (rom_idx),
      .sine      (rom_val)
   );

   // Handshakes
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Velocity errors for smoothing
   always_comb begin
      diff_x = {cmd_x_ff[23], cmd_x_ff} - {vel_x_ff[23], vel_x_ff};
      diff_y = {cmd_y_ff[23], cmd_y_ff} - {vel_y_ff[23], vel_y_ff};
      diff_r = {cmd_r_ff[23], cmd_r_ff} - {rate_ff[23], rate_ff};
   end

   // Sine at the first step, cosine (quarter turn ahead) at the second
   always_comb begin
      head_idx = head_ff[15 -: TABLE_BITS];
      if (step_ff == STEP_SMOOTH_Y) begin
         rom_idx = head_idx + TABLE_BITS'(QUAR_LEN);
      end else begin
         rom_idx = head_idx;
      end
   end

   // Select the multiplier operands for the current step
   always_comb begin
      case (step_ff)
         STEP_SMOOTH_X: begin
            mul_op.a = MUL_A_W'(diff_x);
            mul_op.b = {1'b0, gain_ff};
         end
         STEP_SMOOTH_Y: begin
            mul_op.a = MUL_A_W'(diff_y);
            mul_op.b = {1'b0, gain_ff};
         end
         STEP_SMOOTH_R: begin
            mul_op.a = MUL_A_W'(diff_r);
            mul_op.b = {1'b0, gain_ff};
         end
         STEP_VX_COS: begin
            mul_op.a = MUL_A_W'(vel_x_ff);
            mul_op.b = MUL_B_W'(cos_ff);
         end
         STEP_VY_SIN: begin
            mul_op.a = MUL_A_W'(vel_y_ff);
            mul_op.b = MUL_B_W'(sin_ff);
         end
         STEP_VX_SIN: begin
            mul_op.a = MUL_A_W'(vel_x_ff);
            mul_op.b = MUL_B_W'(sin_ff);
         end
         STEP_VY_COS: begin
            mul_op.a = MUL_A_W'(vel_y_ff);
            mul_op.b = MUL_B_W'(cos_ff);
         end
         STEP_WX_DT: begin
            mul_op.a = wx_ff;
            mul_op.b = {1'b0, dt_ff};
         end
         STEP_WY_DT: begin
            mul_op.a = acc_ff;
            mul_op.b = {1'b0, dt_ff};
         end
         STEP_RATE_DT: begin
            mul_op.a = MUL_A_W'(rate_ff);
            mul_op.b = {1'b0, dt_ff};
         end
         default: begin
            mul_op.a = '0;
            mul_op.b = '0;
         end
      endcase
   end

   // Floor-shifted smoothing increment and the low product bits
   assign smooth_step = prod[39:16];
   assign prod_low    = prod[MUL_A_W-1:0];

   // Next state of the sequencer and the integrator
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      gain_in      = gain_ff;
      dt_in        = dt_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      head_in      = head_ff;
      vel_x_in     = vel_x_ff;
      vel_y_in     = vel_y_ff;
      rate_in      = rate_ff;
      cmd_x_in     = cmd_x_ff;
      cmd_y_in     = cmd_y_ff;
      cmd_r_in     = cmd_r_ff;
      sin_in       = sin_ff;
      cos_in       = cos_ff;
      acc_in       = acc_ff;
      wx_in        = wx_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_head_in  = out_head_ff;
      out_vx_in    = out_vx_ff;
      out_vy_in    = out_vy_ff;
      out_rate_in  = out_rate_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      // Register writes
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SMOOTHING_GAIN: gain_in = csr_wdata;
            CSR_STEP_TIME:      dt_in   = csr_wdata;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            step_in = STEP_SMOOTH_X;
            if (accept) begin
               cmd_x_in = req_cmd_vel_x;
               cmd_y_in = req_cmd_vel_y;
               cmd_r_in = req_cmd_turn_rate;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            step_in = step_ff + 4'd1;
            case (step_ff)
               STEP_SMOOTH_Y: begin
                  vel_x_in = vel_x_ff + smooth_step;
                  sin_in   = rom_val;
               end
               STEP_SMOOTH_R: begin
                  vel_y_in = vel_y_ff + smooth_step;
                  cos_in   = rom_val;
               end
               STEP_VX_COS: rate_in = rate_ff + smooth_step;
               STEP_VY_SIN: acc_in = prod_low;
               STEP_VX_SIN: acc_in = acc_ff - prod_low;
               STEP_VY_COS: begin
                  wx_in  = acc_ff;
                  acc_in = prod_low;
               end
               STEP_WX_DT: acc_in = acc_ff + prod_low;
               STEP_WY_DT: pos_x_in = sat_add(pos_x_ff, prod[57:31]);
               STEP_RATE_DT: pos_y_in = sat_add(pos_y_ff, prod[57:31]);
               STEP_HEADING: begin
                  head_in  = head_ff + angle_type'(prod[31:16]);
                  step_in  = STEP_SMOOTH_X;
                  state_in = ST_DONE;
               end
               default: ;
            endcase
         end
         ST_DONE: begin
            if (out_load) begin
               out_x_in     = pos_x_ff;
               out_y_in     = pos_y_ff;
               out_head_in  = head_ff;
               out_vx_in    = vel_x_ff;
               out_vy_in    = vel_y_ff;
               out_rate_in  = rate_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   // Control and integrator state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_SMOOTH_X;
         gain_ff      <= SMOOTHING_GAIN_RESET;
         dt_ff        <= STEP_TIME_RESET;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         head_ff      <= '0;
         vel_x_ff     <= '0;
         vel_y_ff     <= '0;
         rate_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         gain_ff      <= gain_in;
         dt_ff        <= dt_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         head_ff      <= head_in;
         vel_x_ff     <= vel_x_in;
         vel_y_ff     <= vel_y_in;
         rate_ff      <= rate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_x_ff    <= cmd_x_in;
      cmd_y_ff    <= cmd_y_in;
      cmd_r_ff    <= cmd_r_in;
      sin_ff      <= sin_in;
      cos_ff      <= cos_in;
      acc_ff      <= acc_in;
      wx_ff       <= wx_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_head_ff <= out_head_in;
      out_vx_ff   <= out_vx_in;
      out_vy_ff   <= out_vy_in;
      out_rate_ff <= out_rate_in;
   end

   // Result word
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pose_x         = out_x_ff;
   assign rsp_pose_y         = out_y_ff;
   assign rsp_heading        = out_head_ff;
   assign rsp_body_vel_x     = out_vx_ff;
   assign rsp_body_vel_y     = out_vy_ff;
   assign rsp_body_turn_rate = out_rate_ff;

   // Checks on the sequencer
   `PPI_ASSERT_NOW(a_step_parked, state_ff != ST_RUN, step_ff == STEP_SMOOTH_X,
                   "step counter moved outside run")
   `PPI_ASSERT_NEXT(a_accept_starts, accept,
                    (state_ff == ST_RUN) && (step_ff == STEP_SMOOTH_X),
                    "accepted word did not start the sequence")
   `PPI_ASSERT_NEXT(a_last_step_done, (state_ff == ST_RUN) && (step_ff == STEP_HEADING),
                    state_ff == ST_DONE, "sequence did not finish after the heading step")
   `PPI_ASSERT_NEXT(a_result_loaded, out_load, rsp_valid_ff && (state_ff == ST_IDLE),
                    "finished word not presented on the result channel")

endmodule
